>>> rtl/rhsm_pkg.sv
// ----------------------------------------------------------------------------
// rhsm_pkg
// Shared types, constants and arithmetic helpers of the rolling hash
// substring matcher.
// ----------------------------------------------------------------------------
package rhsm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;
  localparam int MODE_W      = 2;
  localparam int HASH_W      = 30;
  localparam int MUL_STEPS   = CHAR_W;
  localparam int MCNT_W      = $clog2(MUL_STEPS + 1);

  localparam logic [HASH_W-1:0] HASH_MOD  = HASH_W'(1000000000);
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_value;
  } in_item_t;

  typedef struct packed {
    logic match_here;
    logic found;
    logic pattern_overflow;
  } out_item_t;

  // (2*h + c) mod HASH_MOD, h already reduced
  function automatic logic [HASH_W-1:0] mod_dbl_add(input logic [HASH_W-1:0] h,
                                                    input logic [CHAR_W-1:0] c);
    logic [HASH_W:0] s;
    s = {h, 1'b0} + (HASH_W+1)'(c);
    if (s >= {HASH_MOD, 1'b0}) begin
      s = s - {HASH_MOD, 1'b0};
    end else if (s >= (HASH_W+1)'(HASH_MOD)) begin
      s = s - (HASH_W+1)'(HASH_MOD);
    end
    return s[HASH_W-1:0];
  endfunction

  // (a + b) mod HASH_MOD, both reduced
  function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = (HASH_W+1)'(a) + (HASH_W+1)'(b);
    if (s >= (HASH_W+1)'(HASH_MOD)) begin
      s = s - (HASH_W+1)'(HASH_MOD);
    end
    return s[HASH_W-1:0];
  endfunction

  // (ptr - len) mod MAX_PATTERN, len in 1..MAX_PATTERN
  function automatic logic [PTR_W-1:0] wrap_sub(input logic [PTR_W-1:0] ptr,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W:0] s;
    s = (LEN_W+1)'(ptr) + (LEN_W+1)'(MAX_PATTERN) - (LEN_W+1)'(len);
    if (s >= (LEN_W+1)'(MAX_PATTERN)) begin
      s = s - (LEN_W+1)'(MAX_PATTERN);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] r;
    if (ptr == PTR_W'(MAX_PATTERN - 1)) begin
      r = '0;
    end else begin
      r = ptr + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

>>> rtl/rhsm_ram.sv
// ----------------------------------------------------------------------------
// rhsm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rhsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rhsm_mulmod.sv
// ----------------------------------------------------------------------------
// rhsm_mulmod
// Bit-serial modular multiplier: a * b mod 10^9, one bit of b per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
module rhsm_mulmod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rhsm_pkg::HASH_W-1:0] a,
  input  logic [rhsm_pkg::CHAR_W-1:0] b,
  output logic                        busy,
  output logic [rhsm_pkg::HASH_W-1:0] result
);

  logic                        busy_r, busy_nxt;
  logic [rhsm_pkg::MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [rhsm_pkg::HASH_W-1:0] a_r, a_nxt;
  logic [rhsm_pkg::CHAR_W-1:0] b_r, b_nxt;
  logic [rhsm_pkg::HASH_W-1:0] acc_r, acc_nxt;
  logic [rhsm_pkg::HASH_W-1:0] dbl;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    dbl      = rhsm_pkg::mod_dbl_add(acc_r, '0);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rhsm_pkg::MCNT_W'(rhsm_pkg::MUL_STEPS);
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = b_r[rhsm_pkg::CHAR_W-1] ? rhsm_pkg::mod_add(dbl, a_r) : dbl;
      b_nxt   = {b_r[rhsm_pkg::CHAR_W-2:0], 1'b0};
      cnt_nxt = cnt_r - rhsm_pkg::MCNT_W'(1);
      if (cnt_r == rhsm_pkg::MCNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy   = busy_r;
  assign result = acc_r;

endmodule

>>> rtl/rolling_hash_substring_matcher.sv
// ----------------------------------------------------------------------------
// rolling_hash_substring_matcher
// Streaming substring matcher: pattern bytes are loaded, then text bytes are
// scanned with a base-2 rolling hash mod 10^9 and hash hits are verified.
// ----------------------------------------------------------------------------
// Every item gives exactly one result. Clear, pattern, unused-mode and
// dropped (digit, or empty pattern) text items go from S_DISP straight to
// S_DONE; a text item while the window is still filling passes S_SHIFT too.
// Once the window is full, removing the oldest byte needs top_power times
// that byte mod 10^9, done by a bit-serial multiplier at one bit per cycle
// (states S_MUL and S_MULW) before S_SHIFT. On a hash hit the window is
// checked against the pattern one byte at a time, alternating S_VRD and
// S_VCMP (one read port on each of the pattern and window RAMs). A new
// item is accepted while the previous result is still held on the output.
// ----------------------------------------------------------------------------
module rolling_hash_substring_matcher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rhsm_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rhsm_pkg::out_item_t  out_item
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_MULW  = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_VRD   = 4'd5;
  localparam logic [3:0] S_VCMP  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]                  state_r, state_nxt;
  rhsm_pkg::in_item_t          item_r, item_nxt;
  logic [rhsm_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [rhsm_pkg::LEN_W-1:0]  kept_r, kept_nxt;
  logic [rhsm_pkg::PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [rhsm_pkg::HASH_W-1:0] phash_r, phash_nxt;
  logic [rhsm_pkg::HASH_W-1:0] whash_r, whash_nxt;
  logic [rhsm_pkg::HASH_W-1:0] tpow_r, tpow_nxt;
  logic                        found_r, found_nxt;
  logic [rhsm_pkg::HASH_W-1:0] hsel_r, hsel_nxt;
  logic                        res_match_r, res_match_nxt;
  logic                        res_ovf_r, res_ovf_nxt;
  logic [rhsm_pkg::PTR_W-1:0]  walk_j_r, walk_j_nxt;
  logic [rhsm_pkg::PTR_W-1:0]  walk_idx_r, walk_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rhsm_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                        accept;
  logic                        out_load;
  logic                        is_digit;
  logic                        pat_we;
  logic                        ring_we;
  logic [rhsm_pkg::PTR_W-1:0]  ring_raddr;
  logic [rhsm_pkg::CHAR_W-1:0] pat_rdata;
  logic [rhsm_pkg::CHAR_W-1:0] ring_rdata;
  logic                        mul_start;
  logic                        mul_busy;
  logic [rhsm_pkg::HASH_W-1:0] mul_res;
  logic [rhsm_pkg::HASH_W-1:0] new_hash;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign is_digit = (item_r.char_value >= rhsm_pkg::CHAR_ZERO) &&
                    (item_r.char_value <= rhsm_pkg::CHAR_NINE);
  assign new_hash = rhsm_pkg::mod_dbl_add(hsel_r, item_r.char_value);
  assign pat_we   = (state_r == S_DISP) && (item_r.mode == rhsm_pkg::MODE_PATTERN) &&
                    (len_r < rhsm_pkg::LEN_W'(rhsm_pkg::MAX_PATTERN));
  assign ring_we  = (state_r == S_SHIFT);
  assign ring_raddr = (state_r == S_DISP) ? rhsm_pkg::wrap_sub(ptr_r, len_r) : walk_idx_r;
  assign mul_start  = (state_r == S_MUL);

  rhsm_ram #(
    .WIDTH (rhsm_pkg::CHAR_W),
    .DEPTH (rhsm_pkg::MAX_PATTERN)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (len_r[rhsm_pkg::PTR_W-1:0]),
    .wdata (item_r.char_value),
    .raddr (walk_j_r),
    .rdata (pat_rdata)
  );

  rhsm_ram #(
    .WIDTH (rhsm_pkg::CHAR_W),
    .DEPTH (rhsm_pkg::MAX_PATTERN)
  ) u_window_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (item_r.char_value),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  rhsm_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (tpow_r),
    .b      (ring_rdata),
    .busy   (mul_busy),
    .result (mul_res)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    len_nxt       = len_r;
    kept_nxt      = kept_r;
    ptr_nxt       = ptr_r;
    phash_nxt     = phash_r;
    whash_nxt     = whash_r;
    tpow_nxt      = tpow_r;
    found_nxt     = found_r;
    hsel_nxt      = hsel_r;
    res_match_nxt = res_match_r;
    res_ovf_nxt   = res_ovf_r;
    walk_j_nxt    = walk_j_r;
    walk_idx_nxt  = walk_idx_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt  = in_item;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_match_nxt = 1'b0;
        res_ovf_nxt   = 1'b0;
        state_nxt     = S_DONE;
        case (item_r.mode)
          rhsm_pkg::MODE_CLEAR: begin
            len_nxt   = '0;
            kept_nxt  = '0;
            ptr_nxt   = '0;
            phash_nxt = '0;
            whash_nxt = '0;
            tpow_nxt  = rhsm_pkg::HASH_W'(1);
            found_nxt = 1'b0;
          end
          rhsm_pkg::MODE_PATTERN: begin
            if (pat_we) begin
              if (len_r != '0) begin
                tpow_nxt = rhsm_pkg::mod_dbl_add(tpow_r, '0);
              end
              phash_nxt = rhsm_pkg::mod_dbl_add(phash_r, item_r.char_value);
              len_nxt   = len_r + rhsm_pkg::LEN_W'(1);
            end else begin
              res_ovf_nxt = 1'b1;
            end
            kept_nxt  = '0;
            ptr_nxt   = '0;
            whash_nxt = '0;
          end
          rhsm_pkg::MODE_TEXT: begin
            if (!is_digit && len_r != '0) begin
              if (kept_r >= len_r) begin
                state_nxt = S_MUL;
              end else begin
                kept_nxt  = kept_r + rhsm_pkg::LEN_W'(1);
                hsel_nxt  = whash_r;
                state_nxt = S_SHIFT;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        state_nxt = S_MULW;
      end
      S_MULW: begin
        if (!mul_busy) begin
          hsel_nxt  = rhsm_pkg::mod_add(whash_r, rhsm_pkg::HASH_MOD - mul_res);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        whash_nxt = new_hash;
        ptr_nxt   = rhsm_pkg::wrap_inc(ptr_r);
        if (kept_r >= len_r && new_hash == phash_r) begin
          walk_j_nxt   = '0;
          walk_idx_nxt = rhsm_pkg::wrap_sub(rhsm_pkg::wrap_inc(ptr_r), len_r);
          state_nxt    = S_VRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_VRD: begin
        state_nxt = S_VCMP;
      end
      S_VCMP: begin
        if (pat_rdata != ring_rdata) begin
          state_nxt = S_DONE;
        end else if (rhsm_pkg::LEN_W'(walk_j_r) == len_r - rhsm_pkg::LEN_W'(1)) begin
          res_match_nxt = 1'b1;
          found_nxt     = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          walk_j_nxt   = walk_j_r + rhsm_pkg::PTR_W'(1);
          walk_idx_nxt = rhsm_pkg::wrap_inc(walk_idx_r);
          state_nxt    = S_VRD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt                 = 1'b1;
          out_item_nxt.match_here       = res_match_r;
          out_item_nxt.found            = found_r || (len_r == '0);
          out_item_nxt.pattern_overflow = res_ovf_r;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      kept_r      <= '0;
      ptr_r       <= '0;
      phash_r     <= '0;
      whash_r     <= '0;
      tpow_r      <= rhsm_pkg::HASH_W'(1);
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      kept_r      <= kept_nxt;
      ptr_r       <= ptr_nxt;
      phash_r     <= phash_nxt;
      whash_r     <= whash_nxt;
      tpow_r      <= tpow_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    hsel_r      <= hsel_nxt;
    res_match_r <= res_match_nxt;
    res_ovf_r   <= res_ovf_nxt;
    walk_j_r    <= walk_j_nxt;
    walk_idx_r  <= walk_idx_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_kept_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= len_r) else $error("kept count above pattern length");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= rhsm_pkg::LEN_W'(rhsm_pkg::MAX_PATTERN)) else $error("pattern length overflow");

  a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    phash_r < rhsm_pkg::HASH_MOD && whash_r < rhsm_pkg::HASH_MOD &&
    tpow_r < rhsm_pkg::HASH_MOD) else $error("hash state not reduced");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("input taken while busy");

  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.match_here |-> out_item_r.found)
    else $error("match without found");

endmodule

>>> sim/tb_rolling_hash_substring_matcher.sv
// ----------------------------------------------------------------------------
// tb_rolling_hash_substring_matcher
// Self-checking bench for the rolling hash substring matcher. A directed
// run covers byte extremes, every mode, digit dropping, the empty pattern,
// unused mode codes and restarting the window with a pattern byte. Random
// runs then load patterns from a small alphabet, so hash hits and
// collisions are frequent. They also fill and overflow the pattern store
// and stream text that wraps the window. Both channels idle and stall at
// random. A scoreboard predicts one result per accepted item and compares
// each delivered result in order.
// ----------------------------------------------------------------------------
module tb_rolling_hash_substring_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rhsm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  class substring_scoreboard;
    logic [rhsm_pkg::CHAR_W-1:0] pat_mem[rhsm_pkg::MAX_PATTERN];
    logic [rhsm_pkg::CHAR_W-1:0] ring_mem[rhsm_pkg::MAX_PATTERN];
    int unsigned         pat_len;
    int unsigned         kept;
    int unsigned         ring_ptr;
    longint unsigned     pat_hash;
    longint unsigned     win_hash;
    longint unsigned     top_pow;
    bit                  seen;
    rhsm_pkg::out_item_t pending_results[$];
    int                  errors;

    function new();
      errors = 0;
      clear_all();
    endfunction

    function void clear_all();
      pat_len  = 0;
      kept     = 0;
      ring_ptr = 0;
      pat_hash = 0;
      win_hash = 0;
      top_pow  = 1;
      seen     = 1'b0;
    endfunction

    function bit window_hits();
      int unsigned start;
      start = (ring_ptr + rhsm_pkg::MAX_PATTERN - pat_len) % rhsm_pkg::MAX_PATTERN;
      for (int unsigned j = 0; j < pat_len; j++) begin
        if (ring_mem[(start + j) % rhsm_pkg::MAX_PATTERN] != pat_mem[j]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(rhsm_pkg::in_item_t it);
      longint unsigned modv;
      longint unsigned h;
      longint unsigned sub;
      int unsigned     old_idx;
      logic [rhsm_pkg::CHAR_W-1:0] c;
      rhsm_pkg::out_item_t         res;
      modv = longint'(rhsm_pkg::HASH_MOD);
      c    = it.char_value;
      res  = '0;
      case (it.mode)
        rhsm_pkg::MODE_CLEAR: begin
          clear_all();
        end
        rhsm_pkg::MODE_PATTERN: begin
          if (pat_len >= rhsm_pkg::MAX_PATTERN) begin
            res.pattern_overflow = 1'b1;
          end else begin
            pat_mem[pat_len] = c;
            if (pat_len > 0) top_pow = (top_pow * 2) % modv;
            pat_hash = (pat_hash * 2 + c) % modv;
            pat_len++;
          end
          kept     = 0;
          ring_ptr = 0;
          win_hash = 0;
        end
        rhsm_pkg::MODE_TEXT: begin
          if (!(c >= rhsm_pkg::CHAR_ZERO && c <= rhsm_pkg::CHAR_NINE) && pat_len > 0) begin
            h = win_hash;
            if (kept >= pat_len) begin
              old_idx = (ring_ptr + rhsm_pkg::MAX_PATTERN - pat_len) % rhsm_pkg::MAX_PATTERN;
              sub = (top_pow * ring_mem[old_idx]) % modv;
              h = (h + modv - sub) % modv;
            end else begin
              kept++;
            end
            win_hash = (h * 2 + c) % modv;
            ring_mem[ring_ptr] = c;
            ring_ptr = (ring_ptr + 1) % rhsm_pkg::MAX_PATTERN;
            if (kept >= pat_len && win_hash == pat_hash && window_hits()) begin
              res.match_here = 1'b1;
              seen = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      res.found = seen || (pat_len == 0);
      pending_results.push_back(res);
    endfunction

    function void check_result(rhsm_pkg::out_item_t got);
      rhsm_pkg::out_item_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %b with nothing pending", got);
        return;
      end
      exp = pending_results.pop_front();
      if (got.match_here !== exp.match_here || got.found !== exp.found ||
          got.pattern_overflow !== exp.pattern_overflow) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: match_here exp %b got %b, found exp %b got %b,",
                   $realtime, exp.match_here, got.match_here, exp.found, got.found,
                   " overflow exp %b got %b",
                   exp.pattern_overflow, got.pattern_overflow);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  rhsm_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rhsm_pkg::out_item_t out_item;

  substring_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;

  rolling_hash_substring_matcher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("rolling_hash_substring_matcher test failed");
    $finish;
  end

  // result side: check accepted results, then pick the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
      out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_item(input logic [rhsm_pkg::MODE_W-1:0] m,
                           input logic [rhsm_pkg::CHAR_W-1:0] c);
    rhsm_pkg::in_item_t it;
    it.mode       = m;
    it.char_value = c;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  function automatic logic [rhsm_pkg::CHAR_W-1:0] pick_letter(bit wide);
    if (wide) return rhsm_pkg::CHAR_W'($urandom_range(255));
    return rhsm_pkg::CHAR_W'("a" + $urandom_range(3));
  endfunction

  function automatic logic [rhsm_pkg::CHAR_W-1:0] pick_digit();
    return rhsm_pkg::CHAR_W'(rhsm_pkg::CHAR_ZERO + $urandom_range(9));
  endfunction

  task automatic run_noise();
    for (int k = 0; k < 20; k++) begin
      send_item(rhsm_pkg::MODE_W'($urandom_range(3)), rhsm_pkg::CHAR_W'($urandom_range(255)));
    end
  endtask

  task automatic run_scenario(input int forced_len);
    logic [rhsm_pkg::CHAR_W-1:0] pat[$];
    logic [rhsm_pkg::CHAR_W-1:0] b;
    bit wide;
    int plen;
    int ntext;
    int k;
    int r;
    wide = ($urandom_range(4) == 0);
    send_item(rhsm_pkg::MODE_CLEAR, rhsm_pkg::CHAR_W'($urandom_range(255)));
    if (forced_len > 0) begin
      plen = forced_len;
    end else begin
      r = $urandom_range(99);
      if (r < 70)      plen = $urandom_range(6, 1);
      else if (r < 92) plen = $urandom_range(20, 7);
      else if (r < 97) plen = $urandom_range(64, 60);
      else             plen = $urandom_range(68, 65);
    end
    for (k = 0; k < plen; k++) begin
      b = pick_letter(wide);
      if (pat.size() < rhsm_pkg::MAX_PATTERN) pat.push_back(b);
      send_item(rhsm_pkg::MODE_PATTERN, b);
    end
    ntext = (plen > 20) ? $urandom_range(20, 5) : $urandom_range(90, 10);
    k = 0;
    while (k < ntext) begin
      r = $urandom_range(99);
      if (r < 25) begin
        // a full occurrence, digits sprinkled in
        foreach (pat[j]) begin
          if ($urandom_range(9) == 0) send_item(rhsm_pkg::MODE_TEXT, pick_digit());
          send_item(rhsm_pkg::MODE_TEXT, pat[j]);
        end
        k += pat.size();
      end else if (r < 27) begin
        b = pick_letter(wide);
        if (pat.size() < rhsm_pkg::MAX_PATTERN) pat.push_back(b);
        send_item(rhsm_pkg::MODE_PATTERN, b);
        k++;
      end else if (r < 29) begin
        send_item(MODE_UNUSED, rhsm_pkg::CHAR_W'($urandom_range(255)));
        k++;
      end else begin
        r = $urandom_range(99);
        if (r < 10)      b = pick_digit();
        else if (r < 20) b = rhsm_pkg::CHAR_W'($urandom_range(255));
        else if (r < 65) b = pat[$urandom_range(pat.size() - 1)];
        else             b = pick_letter(wide);
        send_item(rhsm_pkg::MODE_TEXT, b);
        k++;
      end
    end
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(rhsm_pkg::MODE_TEXT, "a");
    send_item(MODE_UNUSED, 8'hff);
    send_item(rhsm_pkg::MODE_CLEAR, 8'hff);
    send_item(rhsm_pkg::MODE_PATTERN, 8'h00);
    send_item(rhsm_pkg::MODE_PATTERN, 8'hff);
    send_item(rhsm_pkg::MODE_TEXT, 8'h00);
    send_item(rhsm_pkg::MODE_TEXT, rhsm_pkg::CHAR_ZERO);
    send_item(rhsm_pkg::MODE_TEXT, rhsm_pkg::CHAR_NINE);
    send_item(rhsm_pkg::MODE_TEXT, 8'hff);
    send_item(rhsm_pkg::MODE_TEXT, 8'h2f);
    send_item(rhsm_pkg::MODE_TEXT, 8'h3a);
    send_item(rhsm_pkg::MODE_TEXT, 8'h00);
    send_item(rhsm_pkg::MODE_TEXT, "5");
    send_item(rhsm_pkg::MODE_TEXT, 8'hff);
    send_item(rhsm_pkg::MODE_PATTERN, 8'h55);
    send_item(rhsm_pkg::MODE_TEXT, 8'h00);
    send_item(rhsm_pkg::MODE_TEXT, 8'hff);
    send_item(rhsm_pkg::MODE_TEXT, 8'h55);
    send_item(MODE_UNUSED, 8'h00);
    send_item(rhsm_pkg::MODE_CLEAR, 8'h00);
    send_item(rhsm_pkg::MODE_PATTERN, 8'haa);
    send_item(rhsm_pkg::MODE_TEXT, 8'haa);
    send_item(rhsm_pkg::MODE_TEXT, 8'haa);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 30; rx_idle_pct = 49; end
        1:       begin tx_idle_pct = 49; rx_idle_pct = 30; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      target = items_sent + 600;
      run_scenario(64 + 2 * phase);
      while (items_sent < target) begin
        if ($urandom_range(9) == 0) run_noise();
        else run_scenario(0);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("rolling_hash_substring_matcher test passed");
    end else begin
      $display("rolling_hash_substring_matcher test failed");
    end
    $finish;
  end

endmodule
